@@ hw/rtl/gro_pkg.sv @@
// ----------------------------------------------------------------------------
// gro_pkg: shared definitions of the rectangle occupancy grid
// Widths, register indexes, reset values, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package gro_pkg;

    // Largest grid side in cells; the bitmap holds MAX_SIDE rows of MAX_SIDE bits.
    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    // Effective cell count after saturation, 0 to MAX_SIDE.
    localparam int CNTE_W   = SIDE_W + 1;
    // Quotient bits: an in-grid offset is below twice the grid span.
    localparam int QB       = SIDE_W + 1;
    localparam int BIT_W    = $clog2(QB);

    localparam int CNT_W    = 7;
    localparam int SIZE_W   = 12;
    localparam int COORD_W  = 16;

    localparam int PROD_W   = CNTE_W + SIZE_W;
    localparam int OFF_W    = ((PROD_W + 1 > COORD_W + 1) ? PROD_W + 1 : COORD_W + 1) + 1;
    localparam int DSR_W    = SIZE_W + 1 + SIDE_W;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 1'b1;

    localparam logic [CNT_W-1:0]  CELL_COUNT_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] CELL_SIZE_RESET  = 12'd16;

    localparam logic CMD_TEST = 1'b0;
    localparam logic CMD_MARK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_SPAN,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/gro_ram.sv @@
// ----------------------------------------------------------------------------
// gro_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/grid_rectangle_occupancy_core.sv @@
// ----------------------------------------------------------------------------
// grid_rectangle_occupancy_core: rectangle mark and test on an occupancy grid
// Flow: each corner in turn is set up and divided by the shared restoring
// divider, a span step follows, then a row walk unless a corner is outside,
// then the result register; a stalled result holds the sequencer in ST_DONE. One
// word is in work at a time and the next is taken only once the result is
// registered; the shared restoring divider and the single bitmap read port set that.
// Reset (aresetn low, synchronous) restores cell_count 64 and cell_size 16 and
// marks every bitmap row as free at once through per-row valid bits.
// ----------------------------------------------------------------------------
module grid_rectangle_occupancy_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [gro_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gro_pkg::SIZE_W-1:0]    cfg_wdata,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [15:0]            s_corner_a_x,
    input  logic signed [15:0]            s_corner_a_y,
    input  logic signed [15:0]            s_corner_b_x,
    input  logic signed [15:0]            s_corner_b_y,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_region_free,
    output logic                          m_corner_outside
);

    import gro_pkg::*;

    // The bitmap is stored as MAX_SIDE rows, one per x cell index, each row
    // holding one bit per y cell index. A row whose valid bit is clear has
    // never been written since reset and reads as all free.

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cell_count_reg, cell_count_next;
    logic [SIZE_W-1:0] cell_size_reg, cell_size_next;

    // Effective configuration, and the grid span cnt*size, which is registered every
    // cycle so that the multiplier stands alone between registers.
    logic [CNTE_W-1:0] eff_cnt;
    logic [SIZE_W-1:0] eff_sz;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // Captured input word.
    logic                      cmd_reg, cmd_next;
    logic signed [COORD_W-1:0] coord_reg [4];
    logic signed [COORD_W-1:0] coord_next [4];

    // Divider state.
    logic [1:0]       k_reg, k_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [OFF_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [QB-1:0]    q_reg, q_next;
    logic             outside_reg, outside_next;
    logic [SIDE_W-1:0] cell_reg [4];
    logic [SIDE_W-1:0] cell_next [4];

    // Walk state.
    logic [SIDE_W-1:0]   x1_reg, x1_next;
    logic [SIDE_W:0]     rd_x_reg, rd_x_next;
    logic                pend_reg, pend_next;
    logic [SIDE_W-1:0]   pend_x_reg, pend_x_next;
    logic [MAX_SIDE-1:0] mask_reg, mask_next;
    logic                busy_reg, busy_next;
    logic [MAX_SIDE-1:0] row_valid_reg, row_valid_next;

    // Result register.
    logic m_valid_reg, m_valid_next;
    logic m_free_reg, m_free_next;
    logic m_out_reg, m_out_next;

    // Combinational helpers.
    logic signed [OFF_W-1:0] p2;
    logic signed [OFF_W-1:0] prod_ext;
    logic signed [OFF_W-1:0] off2;
    logic                    coord_outside;
    logic [OFF_W:0]          trial;
    logic                    qbit;
    logic [SIDE_W-1:0]       x0, y0, y1;
    logic                    rd_en;
    logic [MAX_SIDE-1:0]     rd_data;
    logic [MAX_SIDE-1:0]     row;
    logic                    wr_en;
    logic [MAX_SIDE-1:0]     wr_data;
    logic                    accept;
    logic                    out_load;
    logic                    div_last;
    logic                    walk_end;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_region_free    = m_free_reg;
    assign m_corner_outside = m_out_reg;

    // Saturate the count to the grid capacity and treat a zero size as one.
    assign eff_cnt = (32'(cell_count_reg) > MAX_SIDE) ? CNTE_W'(MAX_SIDE)
                                                      : CNTE_W'(cell_count_reg);
    assign eff_sz  = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;
    assign prod_next = PROD_W'(eff_cnt) * PROD_W'(eff_sz);

    // Doubled coordinate offset from the grid origin. A corner is outside when
    // the offset is negative or when 2p reaches cnt*size, which is the same as
    // the cell index reaching cnt.
    assign p2       = OFF_W'(coord_reg[k_reg]) <<< 1;
    assign prod_ext = OFF_W'(prod_reg);
    assign off2     = p2 + prod_ext;
    assign coord_outside = off2[OFF_W-1] || (p2 >= prod_ext);

    // One restoring division step against the shifted doubled cell size.
    assign trial = {1'b0, rem_reg} - {1'b0, OFF_W'(dsr_reg)};
    assign qbit  = !trial[OFF_W];
    assign div_last = (bit_reg == '0);

    // Rectangle bounds from the four cell indexes.
    assign x0 = (cell_reg[0] < cell_reg[2]) ? cell_reg[0] : cell_reg[2];
    assign y0 = (cell_reg[1] < cell_reg[3]) ? cell_reg[1] : cell_reg[3];
    assign y1 = (cell_reg[1] < cell_reg[3]) ? cell_reg[3] : cell_reg[1];

    // Walk: a new row is read while the row read in the previous cycle is tested
    // and, for a mark, written back with the rectangle's bits set.
    assign rd_en    = (state_reg == ST_WALK) && (rd_x_reg <= {1'b0, x1_reg});
    assign walk_end = !rd_en && !pend_reg;
    assign row      = row_valid_reg[pend_x_reg] ? rd_data : '0;
    assign wr_en    = (state_reg == ST_WALK) && pend_reg && (cmd_reg == CMD_MARK);
    assign wr_data  = row | mask_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    gro_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pend_x_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_x_reg[SIDE_W-1:0]),
        .rd_data (rd_data)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = (k_reg == 2'd3) ? ST_SPAN : ST_SETUP;
                end
            end
            ST_SPAN: begin
                state_next = outside_reg ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register next values.
    always_comb begin
        cell_count_next = cell_count_reg;
        cell_size_next  = cell_size_reg;
        cmd_next        = cmd_reg;
        coord_next      = coord_reg;
        k_next          = k_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        q_next          = q_reg;
        outside_next    = outside_reg;
        cell_next       = cell_reg;
        x1_next         = x1_reg;
        rd_x_next       = rd_x_reg;
        pend_next       = pend_reg;
        pend_x_next     = pend_x_reg;
        mask_next       = mask_reg;
        busy_next       = busy_reg;
        row_valid_next  = row_valid_reg;
        m_free_next     = m_free_reg;
        m_out_next      = m_out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CELL_COUNT: cell_count_next = cfg_wdata[CNT_W-1:0];
                REG_CELL_SIZE:  cell_size_next  = cfg_wdata;
                default:        cell_size_next  = cell_size_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next      = s_command;
                    coord_next[0] = s_corner_a_x;
                    coord_next[1] = s_corner_a_y;
                    coord_next[2] = s_corner_b_x;
                    coord_next[3] = s_corner_b_y;
                    k_next        = 2'd0;
                    outside_next  = 1'b0;
                end
            end
            ST_SETUP: begin
                rem_next     = off2;
                dsr_next     = DSR_W'({eff_sz, 1'b0}) << SIDE_W;
                bit_next     = BIT_W'(QB - 1);
                outside_next = outside_reg || coord_outside;
            end
            ST_DIV: begin
                if (qbit) begin
                    rem_next = trial[OFF_W-1:0];
                end
                q_next   = {q_reg[QB-2:0], qbit};
                dsr_next = dsr_reg >> 1;
                bit_next = bit_reg - BIT_W'(1);
                if (div_last) begin
                    cell_next[k_reg] = q_next[SIDE_W-1:0];
                    k_next           = k_reg + 2'd1;
                end
            end
            ST_SPAN: begin
                x1_next   = (cell_reg[0] < cell_reg[2]) ? cell_reg[2] : cell_reg[0];
                rd_x_next = {1'b0, x0};
                pend_next = 1'b0;
                busy_next = 1'b0;
                mask_next = ({MAX_SIDE{1'b1}} << y0)
                          & ({MAX_SIDE{1'b1}} >> (SIDE_W'(MAX_SIDE - 1) - y1));
            end
            ST_WALK: begin
                pend_next   = rd_en;
                pend_x_next = rd_x_reg[SIDE_W-1:0];
                if (rd_en) begin
                    rd_x_next = rd_x_reg + (SIDE_W + 1)'(1);
                end
                if (pend_reg) begin
                    busy_next = busy_reg || (|(row & mask_reg));
                end
                if (wr_en) begin
                    row_valid_next[pend_x_reg] = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_free_next  = !outside_reg && !busy_reg;
                    m_out_next   = outside_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cell_count_reg <= CELL_COUNT_RESET;
            cell_size_reg  <= CELL_SIZE_RESET;
            row_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cell_count_reg <= cell_count_next;
            cell_size_reg  <= cell_size_next;
            row_valid_reg  <= row_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        cmd_reg     <= cmd_next;
        coord_reg   <= coord_next;
        k_reg       <= k_next;
        bit_reg     <= bit_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        q_reg       <= q_next;
        outside_reg <= outside_next;
        cell_reg    <= cell_next;
        x1_reg      <= x1_next;
        rd_x_reg    <= rd_x_next;
        pend_reg    <= pend_next;
        pend_x_reg  <= pend_x_next;
        mask_reg    <= mask_next;
        busy_reg    <= busy_next;
        m_free_reg  <= m_free_next;
        m_out_reg   <= m_out_next;
    end

endmodule
